// ===== hdl/hmrp_pkg.sv =====
// Shared types, character codes and byte classification helpers for the height map row parser.
`default_nettype none

package hmrp_pkg;

  localparam int BYTE_W      = 8;
  localparam int HEIGHT_W    = 32;
  localparam int COLOR_W     = 24;
  localparam int ROW_W       = 16;
  localparam int EPL_W       = 11;
  localparam int COL_OUT_W   = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int NIBBLE_W    = 4;
  localparam int SKIP_W      = 2;

  // Number of prefix characters ("0x") skipped after the comma.
  localparam logic [SKIP_W-1:0] PREFIX_LEN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_PER_LINE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_INDEX        = 2'd1;

  localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_0       = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9       = 8'h39;
  localparam logic [BYTE_W-1:0] CH_LC_A    = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LC_F    = 8'h66;
  localparam logic [BYTE_W-1:0] CH_LC_Z    = 8'h7A;
  localparam logic [BYTE_W-1:0] CH_UC_A    = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UC_F    = 8'h46;
  localparam logic [BYTE_W-1:0] CH_UC_Z    = 8'h5A;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_DIGITS = 5'b00010,
    PH_PREFIX = 5'b00100,
    PH_HEX    = 5'b01000,
    PH_SKIP   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic                       emit;
    logic signed [HEIGHT_W-1:0] height;
    logic [COLOR_W-1:0]         color;
  } entry_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0]       column;
    logic [ROW_W-1:0]           row;
    logic signed [HEIGHT_W-1:0] height;
    logic [COLOR_W-1:0]         color;
    logic signed [HEIGHT_W-1:0] z_min;
    logic signed [HEIGHT_W-1:0] z_max;
    logic                       last;
  } result_t;

  function automatic logic is_digit(input logic [BYTE_W-1:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_alpha(input logic [BYTE_W-1:0] c);
    return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
  endfunction

  function automatic logic is_space(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_NEWLINE);
  endfunction

  function automatic logic is_hex(input logic [BYTE_W-1:0] c);
    return is_digit(c) || ((c >= CH_LC_A) && (c <= CH_LC_F)) ||
           ((c >= CH_UC_A) && (c <= CH_UC_F));
  endfunction

  // Letters a-f and A-F both have low nibbles 1..6, so adding nine gives 10..15.
  function automatic logic [NIBBLE_W-1:0] hex_val(input logic [BYTE_W-1:0] c);
    logic [NIBBLE_W-1:0] v;
    if (is_digit(c)) begin
      v = c[NIBBLE_W-1:0];
    end else begin
      v = c[NIBBLE_W-1:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/hmrp_parse_fsm.sv =====
// Entry parser: phase state machine with height and color accumulators.
`default_nettype none

module hmrp_parse_fsm
  import hmrp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [BYTE_W-1:0] text_byte,
  input  wire logic              end_of_text,
  output entry_t                 entry
);

  phase_t                     phase_r, phase_nxt;
  logic signed [HEIGHT_W-1:0] height_r, height_nxt;
  logic                       neg_r, neg_nxt;
  logic [COLOR_W-1:0]         color_r, color_nxt;
  logic [SKIP_W-1:0]          cnt_r, cnt_nxt;
  logic                       term;
  logic                       emit;
  logic [HEIGHT_W-1:0]        digit_ext;
  logic [HEIGHT_W-1:0]        digit_signed;

  // The accumulator holds the signed value directly, so no negation is
  // needed when the entry closes.
  assign digit_ext    = {{(HEIGHT_W-NIBBLE_W){1'b0}}, text_byte[NIBBLE_W-1:0]};
  assign digit_signed = neg_r ? (~digit_ext + 1'b1) : digit_ext;

  always_comb begin
    phase_nxt  = phase_r;
    height_nxt = height_r;
    neg_nxt    = neg_r;
    color_nxt  = color_r;
    cnt_nxt    = cnt_r;
    term       = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (is_digit(text_byte) || (text_byte == CH_PLUS) || (text_byte == CH_MINUS)) begin
          height_nxt = is_digit(text_byte) ? $signed(digit_ext) : '0;
          neg_nxt    = (text_byte == CH_MINUS);
          color_nxt  = '0;
          cnt_nxt    = '0;
          phase_nxt  = PH_DIGITS;
        end
      end
      PH_DIGITS: begin
        if (is_digit(text_byte)) begin
          height_nxt = (height_r <<< 3) + (height_r <<< 1) + $signed(digit_signed);
        end else if (text_byte == CH_COMMA) begin
          cnt_nxt   = '0;
          phase_nxt = PH_PREFIX;
        end else begin
          term = 1'b1;
        end
      end
      PH_PREFIX: begin
        if (is_space(text_byte)) begin
          term = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_nxt >= PREFIX_LEN) begin
            phase_nxt = PH_HEX;
          end
        end
      end
      PH_HEX: begin
        if (is_hex(text_byte)) begin
          color_nxt = {color_r[COLOR_W-NIBBLE_W-1:0], hex_val(text_byte)};
        end else if (is_alpha(text_byte)) begin
          phase_nxt = PH_SKIP;
        end else begin
          term = 1'b1;
        end
      end
      PH_SKIP: begin
        if (!(is_alpha(text_byte) || is_digit(text_byte))) begin
          term = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // End of text closes any entry still open after this byte.
  assign emit = term || (end_of_text && (phase_nxt != PH_IDLE));

  assign entry.emit   = emit;
  assign entry.height = height_nxt;
  assign entry.color  = color_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      height_r <= '0;
      neg_r    <= 1'b0;
      color_r  <= '0;
      cnt_r    <= '0;
    end else if (step) begin
      phase_r  <= emit ? PH_IDLE : phase_nxt;
      height_r <= height_nxt;
      neg_r    <= neg_nxt;
      color_r  <= color_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hmrp_line_track.sv =====
// Line bookkeeping: column counter, line length limit and running min/max height.
`default_nettype none

module hmrp_line_track
  import hmrp_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire entry_t           entry,
  input  wire logic [EPL_W-1:0] entries_per_line,
  input  wire logic [ROW_W-1:0] row_index,
  output result_t               result
);

  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int LEN_W = $clog2(MAX_COLUMNS + 1);
  localparam int CMP_W = (LEN_W > EPL_W) ? LEN_W : EPL_W;
  localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_COLUMNS);

  logic [COL_W-1:0]           col_r, col_nxt;
  logic signed [HEIGHT_W-1:0] min_r, min_nxt;
  logic signed [HEIGHT_W-1:0] max_r, max_nxt;
  logic [CMP_W-1:0]           epl_ext;
  logic [CMP_W-1:0]           len;
  logic [CMP_W-1:0]           col_plus;
  logic                       last;
  logic [COL_W+COL_OUT_W-1:0] col_wide;

  assign epl_ext  = {{(CMP_W-EPL_W){1'b0}}, entries_per_line};
  assign len      = (epl_ext == '0) ? CMP_W'(1) : ((epl_ext > MAX_LEN) ? MAX_LEN : epl_ext);
  assign col_plus = {{(CMP_W-COL_W){1'b0}}, col_r} + 1'b1;
  assign last     = (col_plus >= len);
  assign col_nxt  = last ? '0 : col_plus[COL_W-1:0];

  always_comb begin
    if (col_r == '0) begin
      min_nxt = entry.height;
      max_nxt = entry.height;
    end else begin
      min_nxt = (entry.height < min_r) ? entry.height : min_r;
      max_nxt = (entry.height > max_r) ? entry.height : max_r;
    end
  end

  // Zero-extend or truncate the counter to the fixed column field.
  assign col_wide = {{COL_OUT_W{1'b0}}, col_r};

  assign result.column = col_wide[COL_OUT_W-1:0];
  assign result.row    = row_index;
  assign result.height = entry.height;
  assign result.color  = entry.color;
  assign result.z_min  = min_nxt;
  assign result.z_max  = max_nxt;
  assign result.last   = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      min_r <= '0;
      max_r <= '0;
    end else if (step) begin
      col_r <= col_nxt;
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/height_map_row_parser_core.sv =====
// Top level of the height map row parser: input stage, config registers and result register.
`default_nettype none

// The parser takes map text one byte per beat and emits one result beat for
// every entry it closes: column, row, height, color and the line's running
// minimum and maximum height, plus a flag on the line's last entry. It takes
// one byte every cycle unless the input stage is stalled. A byte is registered
// in the input stage, parsed there by the phase state machine and line
// bookkeeping, and the result lands in the output register. The input stays
// open while a result waits: only a byte that would close an entry while the
// output register is still full holds the input stage, which is the one thing
// that can stall the byte stream. Heights wrap modulo 2^32. Configuration
// writes are always accepted and should be made only while no byte is in
// flight; index 0 sets the number of entries per line (0 counts as 1, values
// above MAX_COLUMNS count as MAX_COLUMNS) and index 1 sets the row number;
// other indexes are ignored. There is no clearing pass after reset.
module height_map_row_parser_core
  import hmrp_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [BYTE_W-1:0]     in_text_byte,
  input  wire logic                  in_end_of_text,

  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [COL_OUT_W-1:0]       out_column,
  output logic [ROW_W-1:0]           out_row,
  output logic signed [HEIGHT_W-1:0] out_height,
  output logic [COLOR_W-1:0]         out_color,
  output logic signed [HEIGHT_W-1:0] out_line_z_min,
  output logic signed [HEIGHT_W-1:0] out_line_z_max,
  output logic                       out_last_in_line,

  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [EPL_W-1:0] epl_r;
  logic [ROW_W-1:0] row_r;

  // Input stage.
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_eot_r;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  result_t           out_r;

  entry_t            entry;
  result_t           result;
  logic              advance;
  logic              emit_go;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epl_r <= EPL_W'(1);
      row_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ENTRIES_PER_LINE: epl_r <= cfg_data[EPL_W-1:0];
        CFG_ROW_INDEX:        row_r <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // The staged byte moves on unless it closes an entry and the result
  // register cannot take the new result this cycle.
  assign advance  = s1_valid_r && (!entry.emit || !out_valid_r || out_ready);
  assign emit_go  = advance && entry.emit;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_text_byte;
      s1_eot_r  <= in_end_of_text;
    end
  end

  hmrp_parse_fsm u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .text_byte   (s1_byte_r),
    .end_of_text (s1_eot_r),
    .entry       (entry)
  );

  hmrp_line_track #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_line (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (emit_go),
    .entry            (entry),
    .entries_per_line (epl_r),
    .row_index        (row_r),
    .result           (result)
  );

  always_comb begin
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_column       = out_r.column;
  assign out_row          = out_r.row;
  assign out_height       = out_r.height;
  assign out_color        = out_r.color;
  assign out_line_z_min   = out_r.z_min;
  assign out_line_z_max   = out_r.z_max;
  assign out_last_in_line = out_r.last;

  // A stalled input stage keeps its byte.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_byte_r) && $stable(s1_eot_r)))
    else $error("input stage lost or changed a stalled byte");

  // A new result is only written when the result register is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while full");

  // Every delivered height lies within the line's running range.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.z_min <= out_r.height) && (out_r.height <= out_r.z_max)))
    else $error("height outside the line's min/max");

  // A result that was not taken stays offered.
  a_out_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("pending result dropped");

endmodule

`default_nettype wire

// ===== verif/height_map_row_parser_core_checker.sv =====
// Scoreboard for the height map row parser: predicts every result beat from the byte stream and checks it.
`default_nettype none

module height_map_row_parser_core_checker
  import hmrp_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  input  wire logic                   in_valid,
  input  wire logic                   in_ready,
  input  wire logic [BYTE_W-1:0]      in_text_byte,
  input  wire logic                   in_end_of_text,

  input  wire logic                   out_valid,
  input  wire logic                   out_ready,
  input  wire logic [COL_OUT_W-1:0]   out_column,
  input  wire logic [ROW_W-1:0]       out_row,
  input  wire logic signed [HEIGHT_W-1:0] out_height,
  input  wire logic [COLOR_W-1:0]     out_color,
  input  wire logic signed [HEIGHT_W-1:0] out_line_z_min,
  input  wire logic signed [HEIGHT_W-1:0] out_line_z_max,
  input  wire logic                   out_last_in_line,

  input  wire logic                   cfg_valid,
  input  wire logic                   cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,

  output int                          fail_count,
  output int                          pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the configuration and of the parser state.
  logic [EPL_W-1:0]           entries_reg;
  logic [ROW_W-1:0]           row_reg;
  phase_t                     phase;
  logic [HEIGHT_W-1:0]        height_acc;
  logic                       minus;
  logic [COLOR_W-1:0]         color_acc;
  logic [SKIP_W-1:0]          prefix_cnt;
  int unsigned                column_pos;
  logic signed [HEIGHT_W-1:0] zmin;
  logic signed [HEIGHT_W-1:0] zmax;

  result_t closed_entries_q[$];
  result_t want;

  function automatic logic digit_byte(input logic [BYTE_W-1:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic logic letter_byte(input logic [BYTE_W-1:0] c);
    return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
  endfunction

  function automatic int hex_nibble(input logic [BYTE_W-1:0] c);
    if (digit_byte(c)) return int'(c - CH_0);
    if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
    if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
    return -1;
  endfunction

  // Closes the open entry: updates the line bookkeeping and queues the result.
  task automatic close_entry();
    int unsigned         span;
    logic [HEIGHT_W-1:0] h;
    logic                at_end;
    result_t             r;
    span = entries_reg;
    if (span == 0) span = 1;
    if (span > MAX_COLUMNS) span = MAX_COLUMNS;
    h = minus ? (32'd0 - height_acc) : height_acc;
    if (column_pos == 0) begin
      zmin = h;
      zmax = h;
    end else begin
      if ($signed(h) > zmax) zmax = h;
      if ($signed(h) < zmin) zmin = h;
    end
    at_end = (column_pos + 1 >= span);
    r.column = column_pos[COL_OUT_W-1:0];
    r.row    = row_reg;
    r.height = h;
    r.color  = color_acc;
    r.z_min  = zmin;
    r.z_max  = zmax;
    r.last   = at_end;
    closed_entries_q.push_back(r);
    column_pos = at_end ? 0 : column_pos + 1;
    phase = PH_IDLE;
  endtask

  task automatic parse_byte(input logic [BYTE_W-1:0] c, input logic eot);
    logic closed;
    int   nib;
    closed = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (digit_byte(c) || c == CH_PLUS || c == CH_MINUS) begin
          height_acc = digit_byte(c) ? HEIGHT_W'(c - CH_0) : '0;
          minus      = (c == CH_MINUS);
          color_acc  = '0;
          prefix_cnt = '0;
          phase      = PH_DIGITS;
        end
      end
      PH_DIGITS: begin
        if (digit_byte(c)) begin
          height_acc = height_acc * 10 + HEIGHT_W'(c - CH_0);
        end else if (c == CH_COMMA) begin
          prefix_cnt = '0;
          phase      = PH_PREFIX;
        end else begin
          close_entry();
          closed = 1'b1;
        end
      end
      PH_PREFIX: begin
        if (c == CH_SPACE || c == CH_NEWLINE) begin
          close_entry();
          closed = 1'b1;
        end else begin
          prefix_cnt = prefix_cnt + 1'b1;
          if (prefix_cnt >= PREFIX_LEN) phase = PH_HEX;
        end
      end
      PH_HEX: begin
        nib = hex_nibble(c);
        if (nib >= 0) begin
          color_acc = {color_acc[COLOR_W-NIBBLE_W-1:0], nib[NIBBLE_W-1:0]};
        end else if (letter_byte(c)) begin
          phase = PH_SKIP;
        end else begin
          close_entry();
          closed = 1'b1;
        end
      end
      default: begin
        if (!(letter_byte(c) || digit_byte(c))) begin
          close_entry();
          closed = 1'b1;
        end
      end
    endcase
    if (eot && !closed && phase != PH_IDLE) close_entry();
  endtask

  task automatic check_field(input string name, input logic signed [63:0] exp_v,
                             input logic signed [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      entries_reg = EPL_W'(1);
      row_reg     = '0;
      phase       = PH_IDLE;
      height_acc  = '0;
      minus       = 1'b0;
      color_acc   = '0;
      prefix_cnt  = '0;
      column_pos  = 0;
      zmin        = '0;
      zmax        = '0;
      closed_entries_q.delete();
      fail_count  = 0;
      pending_results <= 0;
    end else begin
      // A result leaves only after its closing byte has passed the input stage and
      // the result register, so results are checked before this edge's byte is parsed.
      if (out_valid && out_ready) begin
        if (closed_entries_q.size() == 0) begin
          $error("result beat with no closed entry waiting");
          fail_count++;
        end else begin
          want = closed_entries_q.pop_front();
          check_field("column", want.column, out_column);
          check_field("row", want.row, out_row);
          check_field("height", $signed(want.height), out_height);
          check_field("color", want.color, out_color);
          check_field("line_z_min", $signed(want.z_min), out_line_z_min);
          check_field("line_z_max", $signed(want.z_max), out_line_z_max);
          check_field("last_in_line", want.last, out_last_in_line);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ENTRIES_PER_LINE: entries_reg = cfg_data[EPL_W-1:0];
          CFG_ROW_INDEX:        row_reg     = cfg_data[ROW_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) parse_byte(in_text_byte, in_end_of_text);
      pending_results <= closed_entries_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_height_map_row_parser_core.sv =====
// Testbench top for the height map row parser: byte stimulus, result back-pressure and verdict.
`default_nettype none

module tb_height_map_row_parser_core;
  timeunit 1ns;
  timeprecision 1ps;
  import hmrp_pkg::*;

  // Watchdog limit: the run sends roughly 1450 bytes, each with a random gap on
  // both sides, plus the long receiver hold and the settle time before config
  // writes. The limit is set well above that.
  localparam int CYCLE_LIMIT     = 200_000;
  // A byte passes the input stage and the result register before it becomes a
  // result; the settle wait before a config write ensures no byte is still inside the block.
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 8;
  // Long stretch with out_ready low, so that the result register stays full
  // and the input stage has to stall.
  localparam int HOLD_CYCLES     = 300;
  // One line of the widest size plus a few entries, so that the column
  // counter reaches its top value and wraps.
  localparam int FULL_LINE_BEATS = 1030;

  logic                       clk            = 1'b0;
  logic                       rst_n          = 1'b0;
  logic                       in_valid       = 1'b0;
  logic                       in_ready;
  logic [BYTE_W-1:0]          in_text_byte   = '0;
  logic                       in_end_of_text = 1'b0;
  logic                       out_valid;
  logic                       out_ready      = 1'b0;
  logic [COL_OUT_W-1:0]       out_column;
  logic [ROW_W-1:0]           out_row;
  logic signed [HEIGHT_W-1:0] out_height;
  logic [COLOR_W-1:0]         out_color;
  logic signed [HEIGHT_W-1:0] out_line_z_min;
  logic signed [HEIGHT_W-1:0] out_line_z_max;
  logic                       out_last_in_line;
  logic                       cfg_valid      = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index      = '0;
  logic [CFG_DATA_W-1:0]      cfg_data       = '0;

  int fail_count;
  int pending_results;
  int cycles      = 0;
  int entry_bytes = 0;
  // When set, neither side inserts gaps. It is toggled at random so that
  // back-to-back stretches alternate with gappy ones.
  bit quiet       = 1'b0;
  // Raised by the stimulus to ask the result sink for one long hold.
  bit hold_req    = 1'b0;

  always #5 clk = ~clk;

  height_map_row_parser_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_column       (out_column),
    .out_row          (out_row),
    .out_height       (out_height),
    .out_color        (out_color),
    .out_line_z_min   (out_line_z_min),
    .out_line_z_max   (out_line_z_max),
    .out_last_in_line (out_last_in_line),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  height_map_row_parser_core_checker result_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_column       (out_column),
    .out_row          (out_row),
    .out_height       (out_height),
    .out_color        (out_color),
    .out_line_z_min   (out_line_z_min),
    .out_line_z_max   (out_line_z_max),
    .out_last_in_line (out_last_in_line),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending_results  (pending_results)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** height_map_row_parser_core: FAILED **");
      $finish;
    end
  end

  // Offers one byte and returns at the edge that accepts it. With no gap the
  // next byte replaces this one at that same edge, so valid stays high and
  // is assigned only once in that time step.
  task automatic send_byte(input logic [BYTE_W-1:0] c, input logic eot);
    int gap;
    gap = quiet ? 0 : $urandom_range(3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= c;
    in_end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text(input string s, input bit eot_on_last);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_byte(s[i], eot_on_last && (i == s.len() - 1));
    end
  endtask

  // Bytes that belong to a well-formed entry are counted toward the size of
  // a random phase; an end-of-text flag lands on about one byte in forty.
  task automatic send_entry_byte(input logic [BYTE_W-1:0] c);
    entry_bytes++;
    send_byte(c, $urandom_range(39) == 0);
  endtask

  // One entry with random content: optional sign, a digit run that is
  // sometimes long enough to wrap, an optional color with a prefix that is
  // now and then broken, hex digits of both cases (more than six on occasion
  // so the top nibbles fall off), optional trailing letters, and a
  // terminator that is mostly a blank but sometimes any byte or missing.
  task automatic send_random_entry();
    int                sel;
    int                n_digits;
    int                n_hex;
    int                v;
    int                i;
    logic [BYTE_W-1:0] c;
    sel = $urandom_range(9);
    if (sel == 7) send_entry_byte(CH_PLUS);
    else if (sel >= 8) send_entry_byte(CH_MINUS);
    v = $urandom_range(9);
    if (v < 6) n_digits = $urandom_range(1, 3);
    else if (v < 9) n_digits = $urandom_range(4, 8);
    else n_digits = $urandom_range(9, 12);
    if (sel >= 7 && $urandom_range(15) == 0) n_digits = 0;
    for (i = 0; i < n_digits; i++) send_entry_byte(CH_0 + BYTE_W'($urandom_range(9)));
    if ($urandom_range(1) == 1) begin
      send_entry_byte(CH_COMMA);
      send_entry_byte(($urandom_range(7) == 0) ? BYTE_W'($urandom_range(255)) : CH_0);
      send_entry_byte(($urandom_range(7) == 0) ? BYTE_W'($urandom_range(255)) : CH_LC_A + 8'd23);
      n_hex = ($urandom_range(5) == 0) ? $urandom_range(7, 9) : $urandom_range(6);
      for (i = 0; i < n_hex; i++) begin
        v = $urandom_range(15);
        if (v < 10) c = CH_0 + BYTE_W'(v);
        else if ($urandom_range(1) == 1) c = CH_UC_A + BYTE_W'(v - 10);
        else c = CH_LC_A + BYTE_W'(v - 10);
        send_entry_byte(c);
      end
      if ($urandom_range(3) == 0) begin
        // A letter past 'f' starts the skip; digits and letters follow.
        send_entry_byte(($urandom_range(1) == 1 ? CH_UC_A : CH_LC_A) +
                        BYTE_W'($urandom_range(6, 25)));
        for (i = $urandom_range(2); i > 0; i--) begin
          send_entry_byte(($urandom_range(1) == 1) ? CH_0 + BYTE_W'($urandom_range(9)) :
                          CH_LC_A + BYTE_W'($urandom_range(25)));
        end
      end
    end
    v = $urandom_range(9);
    if (v <= 4) send_entry_byte(CH_SPACE);
    else if (v <= 7) send_entry_byte(CH_NEWLINE);
    else if (v == 8) send_entry_byte(BYTE_W'($urandom_range(255)));
  endtask

  // Random phase: mostly well-formed entries, the rest single noise bytes.
  task automatic run_text(input int n_bytes);
    int start;
    start = entry_bytes;
    while (entry_bytes - start < n_bytes) begin
      if ($urandom_range(6) == 0) send_byte(BYTE_W'($urandom_range(255)), $urandom_range(39) == 0);
      else send_random_entry();
      if ($urandom_range(24) == 0) quiet = !quiet;
    end
  endtask

  // Every beat carries end-of-text, so each byte that opens an entry also
  // closes it. Lines fill one column per beat.
  task automatic run_full_line(input int beats);
    int i;
    int v;
    for (i = 0; i < beats; i++) begin
      v = $urandom_range(11);
      send_byte(v < 10 ? CH_0 + BYTE_W'(v) : (v == 10 ? CH_PLUS : CH_MINUS), 1'b1);
      if ($urandom_range(49) == 0) quiet = !quiet;
    end
  endtask

  // Config writes wait until every predicted result has left and the last
  // byte has had time to pass through the block.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Result sink: a random wait before each beat, and one
  // long hold when the stimulus asks for it.
  initial begin : result_sink
    int gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = quiet ? 0 : $urandom_range(3);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, under the reset configuration of one entry per line.
    // Bytes with no entry open are ignored, whatever they are.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // A lone sign gives height zero.
    send_text("+ ", 1'b0);
    // Most negative height, a mixed-case color, then trailing letters skipped.
    send_text("-2147483648,0xaF3g1\n", 1'b0);
    // A blank inside the color prefix closes the entry with no color.
    send_text("5,0 ", 1'b0);
    // Any other byte ends the digits and is dropped.
    send_text("9x", 1'b0);
    // A byte that is neither hex nor a letter ends the color.
    send_text("3,0x1F.", 1'b0);
    // End of text closes an entry opened by the same byte, and is harmless
    // when nothing is open.
    send_text("7", 1'b1);
    send_byte(CH_SPACE, 1'b1);

    write_reg(CFG_ENTRIES_PER_LINE, 16'd3);
    write_reg(CFG_ROW_INDEX, 16'hFFFF);
    run_text(80);

    // Only the low eleven bits land in the register, which leaves zero: one
    // entry per line.
    write_reg(CFG_ENTRIES_PER_LINE, 16'hF800);
    write_reg(CFG_ROW_INDEX, 16'd0);
    run_text(60);

    // Above the column limit, so a line holds the maximum number of entries.
    // The receiver holds off at the start while one-byte entries keep coming.
    write_reg(CFG_ENTRIES_PER_LINE, 16'd2047);
    write_reg(CFG_ROW_INDEX, CFG_DATA_W'($urandom_range(65535)));
    hold_req = 1'b1;
    run_full_line(FULL_LINE_BEATS);

    // The column is now past the new line length, so the next entry ends it.
    write_reg(CFG_ENTRIES_PER_LINE, 16'd2);
    write_reg(CFG_ROW_INDEX, CFG_DATA_W'($urandom_range(65535)));
    run_text(80);

    write_reg(CFG_ENTRIES_PER_LINE, 16'd1024);
    run_text(60);

    write_reg(CFG_ENTRIES_PER_LINE, 16'd1025);
    write_reg(CFG_ROW_INDEX, CFG_DATA_W'($urandom_range(65535)));
    run_text(30);

    write_reg(CFG_ENTRIES_PER_LINE, CFG_DATA_W'($urandom_range(1, 8)));
    run_text(60);
    // Close whatever is still open.
    send_byte(CH_NEWLINE, 1'b1);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("** height_map_row_parser_core: PASSED **");
    end else begin
      $display("** height_map_row_parser_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
